// ----- rtl/kbp_pkg.sv -----
`default_nettype none
package kbp_pkg;

  localparam int MAX_STEPS         = 1024;
  localparam int CORDIC_ITERATIONS = 18;
  localparam int RED_STEPS         = 18;
  localparam int MUL_STEPS         = 25;

  localparam logic [23:0] STEP_TIME_RESET = 24'd6554;

  // angle constants in Q.32, cordic start gain in Q.30
  localparam logic signed [37:0] TWO_PI_Q32     = 38'sd26986075409;
  localparam logic signed [37:0] PI_Q32         = 38'sd13493037705;
  localparam logic signed [37:0] HALF_PI_Q32    = 38'sd6746518852;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_HOR  = 2'd1;
  localparam logic [1:0] ST_MAX_STEPS = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_STEP,
    S_GO,
    S_BUSY,
    S_UPDATE,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    PH_DTV,
    PH_MID,
    PH_DTA,
    PH_DS,
    PH_DK,
    PH_RED,
    PH_ROT,
    PH_X,
    PH_Y
  } phase_e;

  typedef struct packed {
    logic   load;
    logic   check;
    logic   step;
    logic   go;
    logic   run;
    logic   update;
    logic   publish;
    phase_e phase;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic err;
    logic unit_last;
    logic last_step;
    logic out_free;
  } stat_t;

  // rounded arctangent table, Q.30
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] r;
    unique case (idx)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd31: r = 30'd0;
      default: r = 30'd1 << (5'd30 - idx);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/kbp_ctrl.sv -----
`default_nettype none
module kbp_ctrl
  import kbp_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  in_ready_o
);

  state_e state_q, state_d;
  phase_e ph_q, ph_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= PH_DTV;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    unique case (state_q)
      S_IDLE:   if (stat_i.in_valid) state_d = S_CHECK;
      S_CHECK:  state_d = stat_i.err ? S_DONE : S_STEP;
      S_STEP: begin
        state_d = S_GO;
        ph_d    = PH_DTV;
      end
      S_GO:     state_d = S_BUSY;
      S_BUSY: begin
        if (stat_i.unit_last) begin
          if (ph_q == PH_Y) begin
            state_d = S_UPDATE;
          end else begin
            state_d = S_GO;
            ph_d    = phase_e'(ph_q + 4'd1);
          end
        end
      end
      S_UPDATE: state_d = stat_i.last_step ? S_DONE : S_STEP;
      S_DONE:   if (stat_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.phase   = ph_q;
    cmd_o.load    = (state_q == S_IDLE) && stat_i.in_valid;
    cmd_o.check   = (state_q == S_CHECK);
    cmd_o.step    = (state_q == S_STEP);
    cmd_o.go      = (state_q == S_GO);
    cmd_o.run     = (state_q == S_BUSY);
    cmd_o.update  = (state_q == S_UPDATE);
    cmd_o.publish = (state_q == S_DONE) && stat_i.out_free;
    in_ready_o    = (state_q == S_IDLE);
  end

endmodule
`default_nettype wire

// ----- rtl/kbp_datapath.sv -----
`default_nettype none
module kbp_datapath
  import kbp_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  cmd_t         cmd_i,
  output stat_t        stat_o,
  input  wire  [23:0]  step_time_i,
  input  wire          in_valid_i,
  input  wire  [223:0] in_data_i,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output logic [207:0] out_data_o
);

  function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
    if (v > 45'sd2147483647)       return 32'sh7fffffff;
    else if (v < -45'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
    if (v > 34'sd8388607)       return 24'sh7fffff;
    else if (v < -34'sd8388608) return 24'sh800000;
    else                        return v[23:0];
  endfunction

  // working state
  logic        [23:0] hor_q, dt_q;
  logic signed [25:0] remain_q;
  logic               last_q;
  logic signed [31:0] x_q, y_q, z_q, phi_q;
  logic signed [23:0] kap_q, v_q, a_q;
  logic        [1:0]  st_q;

  // step intermediates
  logic signed [32:0] dtv_q, vm_q;
  logic signed [35:0] mid_q;
  logic signed [48:0] dta_q;
  logic signed [40:0] ds_q;
  logic signed [43:0] dk_q, xd_q, yd_q;
  logic signed [23:0] c_q, s_q;

  // shared sequencing counter
  logic [4:0] cnt_q;

  // serial multiplier
  logic signed [66:0] ma_q, acc_q, mul_term, mul_sum;
  logic signed [24:0] mb_q;
  logic signed [66:0] go_a;
  logic signed [24:0] go_b;

  // angle reduction and cordic
  logic        [51:0] mag_q, mag_next;
  logic               rneg_q, fneg_q;
  logic signed [33:0] cx_q, cy_q, cz_q, cx_n, cy_n, cz_n, cx_f, cy_f;
  logic signed [53:0] red_trial;
  logic        [4:0]  red_sh;
  logic signed [37:0] r0, r1, r2;
  logic               fneg_n;
  logic signed [33:0] z0;
  logic signed [35:0] mid_abs;

  // output register
  logic               ov_q;
  logic        [207:0] od_q;

  logic signed [25:0] rem_n;
  logic        [23:0] dt_clamp;
  logic        [1:0]  chk_st;
  logic               unit_last;

  // multiplier operands per phase
  always_comb begin
    go_a = '0;
    go_b = '0;
    unique case (cmd_i.phase)
      PH_DTV:  begin go_a = 67'(v_q);   go_b = $signed({1'b0, dt_q}); end
      PH_MID:  begin go_a = 67'(dtv_q); go_b = 25'(kap_q);            end
      PH_DTA:  begin go_a = 67'(a_q);   go_b = $signed({1'b0, dt_q}); end
      PH_DS:   begin go_a = 67'(vm_q);  go_b = $signed({1'b0, dt_q}); end
      PH_DK:   begin go_a = 67'(ds_q);  go_b = 25'(kap_q);            end
      PH_X:    begin go_a = 67'(ds_q);  go_b = 25'(c_q);              end
      PH_Y:    begin go_a = 67'(ds_q);  go_b = 25'(s_q);              end
      default: begin go_a = '0;         go_b = '0;                    end
    endcase
  end

  // one partial product a cycle, top bit of b has negative weight
  always_comb begin
    if (mb_q[0]) mul_term = (cnt_q == 5'(MUL_STEPS - 1)) ? -ma_q : ma_q;
    else         mul_term = '0;
    mul_sum = acc_q + mul_term;
  end

  // restoring reduction modulo two pi
  always_comb begin
    red_sh    = 5'(RED_STEPS - 1) - cnt_q;
    red_trial = $signed({2'b00, mag_q}) - (54'(TWO_PI_Q32) <<< red_sh);
    mag_next  = red_trial[53] ? mag_q : red_trial[51:0];
    r0 = rneg_q ? -$signed({3'b000, mag_next[34:0]}) : $signed({3'b000, mag_next[34:0]});
    if (r0 > PI_Q32)       r1 = r0 - TWO_PI_Q32;
    else if (r0 < -PI_Q32) r1 = r0 + TWO_PI_Q32;
    else                   r1 = r0;
    fneg_n = 1'b0;
    r2     = r1;
    if (r1 > HALF_PI_Q32) begin
      r2 = r1 - PI_Q32;
      fneg_n = 1'b1;
    end else if (r1 < -HALF_PI_Q32) begin
      r2 = r1 + PI_Q32;
      fneg_n = 1'b1;
    end
    z0 = 34'((r2 + 38'sd2) >>> 2);
    mid_abs = mid_q[35] ? -mid_q : mid_q;
  end

  // cordic rotation step
  always_comb begin
    if (!cz_q[33]) begin
      cx_n = cx_q - (cy_q >>> cnt_q);
      cy_n = cy_q + (cx_q >>> cnt_q);
      cz_n = cz_q - $signed({4'b0000, atan_q30(cnt_q)});
    end else begin
      cx_n = cx_q + (cy_q >>> cnt_q);
      cy_n = cy_q - (cx_q >>> cnt_q);
      cz_n = cz_q + $signed({4'b0000, atan_q30(cnt_q)});
    end
    cx_f = fneg_q ? -cx_n : cx_n;
    cy_f = fneg_q ? -cy_n : cy_n;
  end

  // end of the running unit
  always_comb begin
    unique case (cmd_i.phase)
      PH_RED:  unit_last = (cnt_q == 5'(RED_STEPS - 1));
      PH_ROT:  unit_last = (cnt_q == 5'(CORDIC_ITERATIONS - 1));
      default: unit_last = (cnt_q == 5'(MUL_STEPS - 1));
    endcase
  end

  // horizon and step count check
  always_comb begin
    dt_clamp = (step_time_i >= hor_q) ? hor_q : step_time_i;
    if (hor_q == '0)                chk_st = ST_ZERO_HOR;
    else if (step_time_i == '0)     chk_st = ST_MAX_STEPS;
    else if (41'(hor_q) > 41'(dt_clamp) * 41'(MAX_STEPS)) chk_st = ST_MAX_STEPS;
    else                            chk_st = ST_OK;
    rem_n = remain_q - $signed({2'b00, dt_q});
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hor_q <= in_data_i[23:0];
      x_q   <= in_data_i[55:24];
      y_q   <= in_data_i[87:56];
      z_q   <= in_data_i[119:88];
      phi_q <= in_data_i[151:120];
      kap_q <= in_data_i[175:152];
      v_q   <= in_data_i[199:176];
      a_q   <= in_data_i[223:200];
    end
    if (cmd_i.check) begin
      st_q     <= chk_st;
      dt_q     <= dt_clamp;
      remain_q <= $signed({2'b00, hor_q});
    end
    if (cmd_i.step) begin
      remain_q <= rem_n;
      last_q   <= (rem_n <= 26'sd0);
      if (rem_n <= 26'sd0) dt_q <= remain_q[23:0];
    end
    if (cmd_i.go) begin
      cnt_q <= '0;
      ma_q  <= go_a;
      mb_q  <= go_b;
      acc_q <= '0;
      mag_q <= {mid_abs[35:0], 16'h0000};
      rneg_q <= mid_q[35];
    end
    if (cmd_i.run) begin
      cnt_q <= cnt_q + 5'd1;
      acc_q <= mul_sum;
      ma_q  <= ma_q <<< 1;
      mb_q  <= mb_q >>> 1;
      if (cmd_i.phase == PH_RED) mag_q <= mag_next;
      if (cmd_i.phase == PH_ROT) begin
        cx_q <= cx_n;
        cy_q <= cy_n;
        cz_q <= cz_n;
      end
      if (unit_last) begin
        unique case (cmd_i.phase)
          PH_DTV: dtv_q <= 33'((mul_sum + 67'sd32768) >>> 16);
          PH_MID: mid_q <= 36'(phi_q) + 36'((mul_sum + 67'sd1048576) >>> 21);
          PH_DTA: begin
            dta_q <= mul_sum[48:0];
            vm_q  <= 33'(v_q) + 33'((mul_sum + 67'sd65536) >>> 17);
          end
          PH_DS:  ds_q <= 41'((mul_sum + 67'sd32768) >>> 16);
          PH_DK:  dk_q <= 44'((mul_sum + 67'sd524288) >>> 20);
          PH_RED: begin
            cx_q   <= CORDIC_GAIN_Q30;
            cy_q   <= '0;
            cz_q   <= z0;
            fneg_q <= fneg_n;
          end
          PH_ROT: begin
            c_q <= 24'((cx_f + 34'sd512) >>> 10);
            s_q <= 24'((cy_f + 34'sd512) >>> 10);
          end
          PH_X:   xd_q <= 44'((mul_sum + 67'sd524288) >>> 20);
          PH_Y:   yd_q <= 44'((mul_sum + 67'sd524288) >>> 20);
          default: ;
        endcase
      end
    end
    if (cmd_i.update) begin
      phi_q <= sat32(45'(phi_q) + 45'(dk_q));
      x_q   <= sat32(45'(x_q) + 45'(xd_q));
      y_q   <= sat32(45'(y_q) + 45'(yd_q));
      v_q   <= sat24(34'(v_q) + 34'((50'(dta_q) + 50'sd32768) >>> 16));
    end
  end

  // result register, frees the input side while a result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.publish) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      od_q <= {6'b000000, st_q, a_q, v_q, kap_q, phi_q, z_q, y_q, x_q};
    end
  end

  // status to the controller
  always_comb begin
    stat_o.in_valid  = in_valid_i;
    stat_o.err       = (chk_st != ST_OK);
    stat_o.unit_last = unit_last;
    stat_o.last_step = last_q;
    stat_o.out_free  = !ov_q || out_ready_i;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule
`default_nettype wire

// ----- rtl/kinematic_bicycle_predictor.sv -----
`default_nettype none
// processing: one item at a time; each step runs seven serial multiplies,
// an angle reduction and a cordic on one shared datapath
// a result waits in an output register while the next item is accepted
// reset: asynchronous active low, clears control state, step_time returns to 0.1 s
module kinematic_bicycle_predictor
  import kbp_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  // apb configuration port
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [2:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input stream
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // horizon, start_x, start_y, start_z, start_heading, curvature, start_speed, accel
  input  wire  [223:0] s_axis_tdata,
  // result stream
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // end_x, end_y, end_z, end_heading, end_curvature, end_speed, end_accel, status, pad
  output logic [207:0] m_axis_tdata
);

  logic [23:0] step_time_q;
  cmd_t        cmd;
  stat_t       stat;

  // step_time register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q <= STEP_TIME_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      step_time_q <= pwdata[23:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {8'h00, step_time_q} : 32'h0;

  kbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  kbp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .step_time_i (step_time_q),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire
